### sv/assert_macros.svh
// assertion macros for the encoder rtl
// no dependencies; taken in by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

### sv/abae_pkg.sv
// constants, item types and helpers of the adaptive binary arithmetic encoder
// no dependencies
`default_nettype none

package abae_pkg;

   localparam int COUNT_WIDTH   = 16;
   localparam int CONTEXT_COUNT = 255;
   localparam int CTX_WIDTH     = $clog2(CONTEXT_COUNT);
   localparam int LOW_WIDTH     = 24;
   localparam int HIGH_WIDTH    = LOW_WIDTH + 1;
   localparam int PROD_WIDTH    = LOW_WIDTH + COUNT_WIDTH;
   localparam int STEP_WIDTH    =
      $clog2((COUNT_WIDTH > LOW_WIDTH) ? COUNT_WIDTH : LOW_WIDTH);

   localparam logic [HIGH_WIDTH-1:0]  FULL_RANGE = {1'b1, {LOW_WIDTH{1'b0}}};
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE    = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = '1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] zero;
      logic [COUNT_WIDTH-1:0] one;
   } cnt_pair_type;

   // saturating count increment
   function automatic logic [COUNT_WIDTH-1:0] cnt_bump(input logic [COUNT_WIDTH-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_ONE;
   endfunction

endpackage

`default_nettype wire

### sv/adaptive_binary_arithmetic_encoder.sv
// adaptive binary arithmetic encoder top level; uses abae_pkg and assert_macros.svh
// byte item: 8 coded bits, each read, set up, multiplied serially, divided serially and split,
// then renormalized with one shift for each byte emitted, plus output stalls
// end-of-stream item: 3 output bytes; one item in flight at a time
// reset is synchronous: interval to full range, all context counts back to one at once
`default_nettype none
`include "assert_macros.svh"

module adaptive_binary_arithmetic_encoder (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire abae_pkg::req_type req_item,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output abae_pkg::rsp_type    rsp_item
);

   localparam int CW  = abae_pkg::COUNT_WIDTH;
   localparam int XW  = abae_pkg::CTX_WIDTH;
   localparam int LW  = abae_pkg::LOW_WIDTH;
   localparam int HW  = abae_pkg::HIGH_WIDTH;
   localparam int PW  = abae_pkg::PROD_WIDTH;
   localparam int SW  = abae_pkg::STEP_WIDTH;
   localparam int NCTX = abae_pkg::CONTEXT_COUNT;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_READ   = 4'd1;
   localparam logic [3:0] ST_SETUP  = 4'd2;
   localparam logic [3:0] ST_MUL    = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_SPLIT  = 4'd5;
   localparam logic [3:0] ST_RENORM = 4'd6;
   localparam logic [3:0] ST_DONE   = 4'd7;
   localparam logic [3:0] ST_FLUSH0 = 4'd8;
   localparam logic [3:0] ST_FLUSH1 = 4'd9;
   localparam logic [3:0] ST_FLUSH2 = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [7:0]    byte_ff, byte_in;
   logic [XW-1:0] node_ff, node_in;
   logic [2:0]    bit_cnt_ff, bit_cnt_in;
   logic [SW-1:0] step_ff, step_in;
   logic [LW-1:0] low_ff, low_in;
   logic [HW-1:0] high_ff, high_in;
   logic [CW-1:0] zero_ff, zero_in;
   logic [CW-1:0] one_ff, one_in;
   logic [CW-1:0] mplier_ff, mplier_in;
   logic [CW:0]   div_ff, div_in;
   logic [LW-1:0] span_ff, span_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [CW:0]   rem_ff, rem_in;
   logic [LW-1:0] quo_ff, quo_in;
   logic [7:0]    pend_ff, pend_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   abae_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [NCTX-1:0] ctx_valid_ff, ctx_valid_in;

   abae_pkg::cnt_pair_type cnt_mem [NCTX];
   abae_pkg::cnt_pair_type cnt_rd_ff;
   abae_pkg::cnt_pair_type cnt_upd;
   logic                   rd_valid_ff;

   logic          out_free;
   logic          push;
   abae_pkg::rsp_type push_data;
   logic [HW:0]   range_diff;
   logic          range_small;
   logic [CW-1:0] cur_zero, cur_one;
   logic [HW-1:0] span_w;
   logic [PW-1:0] mul_next;
   logic [PW-1:0] mul_addend;
   logic [CW+1:0] div_trial;
   logic [CW+2:0] div_diff;
   logic          div_ge;
   logic [CW:0]   rem_next;
   logic [LW-1:0] quo_next;
   logic [LW-1:0] mid_raw, mid_a, mid_b;
   logic          cur_bit;
   logic [XW:0]   node_wide;
   logic [HW-1:0] high_dec;
   logic [LW-1:0] low_shift;
   logic [HW-1:0] high_shift, high_wrap;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_data_ff;

   assign range_diff  = {1'b0, high_ff} - {2'b00, low_ff};
   assign range_small = !range_diff[HW] && (range_diff[HW-1:8] == '0);

   assign cur_zero = rd_valid_ff ? cnt_rd_ff.zero : abae_pkg::CNT_ONE;
   assign cur_one  = rd_valid_ff ? cnt_rd_ff.one  : abae_pkg::CNT_ONE;
   assign span_w   = high_ff - {1'b0, low_ff} - HW'(1);

   // shift-add multiply, multiplier msb first
   assign mul_addend = mplier_ff[CW-1] ? {{CW{1'b0}}, span_ff} : '0;
   assign mul_next   = {prod_ff[PW-2:0], 1'b0} + mul_addend;

   // restoring divide, one quotient bit a cycle
   assign div_trial = {rem_ff, quo_ff[LW-1]};
   assign div_diff  = {1'b0, div_trial} - {2'b00, div_ff};
   assign div_ge    = !div_diff[CW+2];
   assign rem_next  = div_ge ? div_diff[CW:0] : div_trial[CW:0];
   assign quo_next  = {quo_ff[LW-2:0], div_ge};

   // split point with both edge corrections
   assign mid_raw = low_ff + quo_ff;
   assign mid_a   = (quo_ff == '0) ? low_ff + LW'(1) : mid_raw;
   assign mid_b   = ({1'b0, mid_a} == high_ff - HW'(1)) ? mid_a - LW'(1) : mid_a;
   assign cur_bit = byte_ff[7];
   assign node_wide = {node_ff, 1'b1} + {{XW{1'b0}}, cur_bit};

   assign cnt_upd.zero = cur_bit ? zero_ff : abae_pkg::cnt_bump(zero_ff);
   assign cnt_upd.one  = cur_bit ? abae_pkg::cnt_bump(one_ff) : one_ff;

   // renormalization step
   assign high_dec   = high_ff - HW'(1);
   assign low_shift  = {low_ff[15:0], 8'h00};
   assign high_shift = {1'b0, high_dec[15:0], 8'h00};
   assign high_wrap  = ({1'b0, low_shift} >= high_shift) ? abae_pkg::FULL_RANGE : high_shift;

   always_comb begin
      state_in      = state_ff;
      byte_in       = byte_ff;
      node_in       = node_ff;
      bit_cnt_in    = bit_cnt_ff;
      step_in       = step_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      zero_in       = zero_ff;
      one_in        = one_ff;
      mplier_in     = mplier_ff;
      div_in        = div_ff;
      span_in       = span_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      ctx_valid_in  = ctx_valid_ff;
      push          = 1'b0;
      push_data     = '{out_byte: pend_ff, last_of_run: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_item.end_of_stream) begin
                  state_in = ST_FLUSH0;
               end else begin
                  byte_in    = req_item.data_byte;
                  node_in    = '0;
                  bit_cnt_in = '0;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            zero_in   = cur_zero;
            one_in    = cur_one;
            mplier_in = cur_zero;
            div_in    = {1'b0, cur_zero} + {1'b0, cur_one};
            span_in   = span_w[LW-1:0];
            prod_in   = '0;
            step_in   = SW'(CW - 1);
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod_in   = mul_next;
            mplier_in = {mplier_ff[CW-2:0], 1'b0};
            if (step_ff == '0) begin
               rem_in   = {1'b0, mul_next[PW-1:LW]};
               quo_in   = mul_next[LW-1:0];
               step_in  = SW'(LW - 1);
               state_in = ST_DIV;
            end else begin
               step_in = step_ff - SW'(1);
            end
         end
         ST_DIV: begin
            rem_in = rem_next;
            quo_in = quo_next;
            if (step_ff == '0) begin
               state_in = ST_SPLIT;
            end else begin
               step_in = step_ff - SW'(1);
            end
         end
         ST_SPLIT: begin
            if (cur_bit) begin
               low_in = mid_b;
            end else begin
               high_in = {1'b0, mid_b};
            end
            ctx_valid_in[node_ff] = 1'b1;
            node_in  = node_wide[XW-1:0];
            byte_in  = {byte_ff[6:0], 1'b0};
            state_in = ST_RENORM;
         end
         ST_RENORM: begin
            if (range_small) begin
               if (!pend_valid_ff || out_free) begin
                  push          = pend_valid_ff;
                  pend_in       = low_ff[23:16];
                  pend_valid_in = 1'b1;
                  low_in        = low_shift;
                  high_in       = high_wrap;
               end
            end else if (bit_cnt_ff == 3'd7) begin
               state_in = ST_DONE;
            end else begin
               bit_cnt_in = bit_cnt_ff + 3'd1;
               state_in   = ST_READ;
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_data     = '{out_byte: pend_ff, last_of_run: 1'b1};
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_FLUSH0: begin
            push_data = '{out_byte: high_dec[23:16], last_of_run: 1'b0};
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_FLUSH1;
            end
         end
         ST_FLUSH1: begin
            push_data = '{out_byte: high_dec[15:8], last_of_run: 1'b0};
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_FLUSH2;
            end
         end
         ST_FLUSH2: begin
            push_data = '{out_byte: high_dec[7:0], last_of_run: 1'b1};
            if (out_free) begin
               push         = 1'b1;
               low_in       = '0;
               high_in      = abae_pkg::FULL_RANGE;
               ctx_valid_in = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ctx_valid_ff  <= '0;
         low_ff        <= '0;
         high_ff       <= abae_pkg::FULL_RANGE;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctx_valid_ff  <= ctx_valid_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      node_ff     <= node_in;
      bit_cnt_ff  <= bit_cnt_in;
      step_ff     <= step_in;
      zero_ff     <= zero_in;
      one_ff      <= one_in;
      mplier_ff   <= mplier_in;
      div_ff      <= div_in;
      span_ff     <= span_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // context count memory, registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_SPLIT) begin
         cnt_mem[node_ff] <= cnt_upd;
      end
      cnt_rd_ff   <= cnt_mem[node_ff];
      rd_valid_ff <= ctx_valid_ff[node_ff];
   end

   `ASSERT_IMPL(a_split_range, clock, reset, state_ff == ST_SPLIT, !range_diff[HW] && !range_small)
   `ASSERT_IMPL(a_quo_bound, clock, reset, state_ff == ST_SPLIT, quo_ff <= span_ff)
   `ASSERT_IMPL(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff)
   `ASSERT_CLK(a_flush_resets, clock, reset,
      (state_ff == ST_FLUSH2 && out_free) |=> (low_ff == '0 &&
      high_ff == abae_pkg::FULL_RANGE && ctx_valid_ff == '0))

endmodule

`default_nettype wire

### verif/abae_coder_compare.sv
// predicts the compressed byte stream of the adaptive binary arithmetic encoder and compares it
// with what the block emits; watches both channels, reports a failure count to the top
// depends on abae_pkg
module abae_coder_compare (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_stall,
   input  abae_pkg::req_type req_item,
   input  wire               rsp_valid,
   input  wire               rsp_stall,
   input  abae_pkg::rsp_type rsp_item,
   output int                mismatch_count,
   output int                pending_count,
   output int                item_count,
   output int                flush_count,
   output int                result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   abae_pkg::rsp_type                expected_bytes[$];
   logic [abae_pkg::LOW_WIDTH-1:0]   coder_low;
   logic [abae_pkg::HIGH_WIDTH-1:0]  coder_high;
   logic [abae_pkg::COUNT_WIDTH-1:0] zero_cnt [abae_pkg::CONTEXT_COUNT];
   logic [abae_pkg::COUNT_WIDTH-1:0] one_cnt [abae_pkg::CONTEXT_COUNT];

   function automatic void clear_coder();
      coder_low  = '0;
      coder_high = abae_pkg::FULL_RANGE;
      for (int k = 0; k < abae_pkg::CONTEXT_COUNT; k++) begin
         zero_cnt[k] = abae_pkg::COUNT_WIDTH'(1);
         one_cnt[k]  = abae_pkg::COUNT_WIDTH'(1);
      end
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // codes one item and queues the output bytes it must produce
   function automatic void predict_coded_bytes(input abae_pkg::req_type it);
      abae_pkg::rsp_type outs[$];
      bit [31:0]  lo, hi, span, mid, ctx, v;
      bit [63:0]  z, o, q;
      bit         one_bit;
      lo = 32'(coder_low);
      hi = 32'(coder_high);
      if (it.end_of_stream) begin
         v = (hi - 32'd1) & 32'h00ff_ffff;
         outs.push_back(abae_pkg::rsp_type'({v[23:16], 1'b0}));
         outs.push_back(abae_pkg::rsp_type'({v[15:8], 1'b0}));
         outs.push_back(abae_pkg::rsp_type'({v[7:0], 1'b0}));
         clear_coder();
      end else begin
         for (int i = 0; i < 8; i++) begin
            one_bit = it.data_byte[7-i];
            ctx     = ((32'd1 << i) - 32'd1) + (32'(it.data_byte) >> (8 - i));
            z       = 64'(zero_cnt[ctx]);
            o       = 64'(one_cnt[ctx]);
            span    = hi - lo - 32'd1;
            q       = (64'(span) * z) / (z + o);
            mid     = lo + q[31:0];
            if (mid == lo) mid = mid + 32'd1;
            if (mid == hi - 32'd1) mid = mid - 32'd1;
            if (one_bit) begin
               lo = mid;
               if (~&one_cnt[ctx]) one_cnt[ctx] = one_cnt[ctx] + 1'b1;
            end else begin
               hi = mid;
               if (~&zero_cnt[ctx]) zero_cnt[ctx] = zero_cnt[ctx] + 1'b1;
            end
            while ((hi - lo) < 32'd256 && outs.size() < 24) begin
               hi = hi - 32'd1;
               outs.push_back(abae_pkg::rsp_type'({lo[23:16], 1'b0}));
               lo = (lo << 8) & 32'h00ff_ff00;
               hi = (hi << 8) & 32'h00ff_ff00;
               if (lo >= hi) hi = 32'h0100_0000;
            end
         end
         coder_low  = lo[abae_pkg::LOW_WIDTH-1:0];
         coder_high = hi[abae_pkg::HIGH_WIDTH-1:0];
      end
      if (outs.size() > 0) outs[outs.size()-1].last_of_run = 1'b1;
      foreach (outs[k]) expected_bytes.push_back(outs[k]);
   endfunction

   function automatic void compare_coded_byte(input abae_pkg::rsp_type got);
      abae_pkg::rsp_type want;
      result_count++;
      if (expected_bytes.size() == 0) begin
         note_mismatch($sformatf("byte %0d: got %02h last %0b with nothing expected",
            result_count, got.out_byte, got.last_of_run));
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run) begin
         note_mismatch($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
            result_count, want.out_byte, want.last_of_run, got.out_byte, got.last_of_run));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_coder();
         expected_bytes.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) compare_coded_byte(rsp_item);
         if (req_valid && !req_stall) begin
            item_count++;
            if (req_item.end_of_stream) flush_count++;
            predict_coded_bytes(req_item);
         end
         pending_count <= expected_bytes.size();
      end
   end

endmodule

### verif/tb_top.sv
// stimulus and verdict for the adaptive binary arithmetic encoder
// depends on abae_pkg, the encoder rtl and abae_coder_compare
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      STYLE_RANDOM,
      STYLE_RUN,
      STYLE_PAIR,
      STYLE_SKEWED,
      STYLE_TEXT
   } stream_style_type;

   localparam int RANDOM_ITEMS = 320;
   localparam int HOLD_CYCLES  = 2000;
   localparam int SETTLE_CYCLES = 1000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   abae_pkg::req_type req_item  = '0;
   logic              rsp_stall = 1'b0;
   wire               req_stall;
   wire               rsp_valid;
   abae_pkg::rsp_type rsp_item;

   int mismatches, pending, items_seen, flushes_seen, results_seen;
   int items_sent;
   bit steady;
   bit hold_receiver;

   adaptive_binary_arithmetic_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   abae_coder_compare coder_compare (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatches),
      .pending_count  (pending),
      .item_count     (items_seen),
      .flush_count    (flushes_seen),
      .result_count   (results_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic abae_pkg::req_type byte_item(input logic [7:0] b);
      abae_pkg::req_type it;
      it.data_byte     = b;
      it.end_of_stream = 1'b0;
      return it;
   endfunction

   function automatic abae_pkg::req_type flush_item();
      abae_pkg::req_type it;
      it.data_byte     = 8'($urandom_range(0, 255));
      it.end_of_stream = 1'b1;
      return it;
   endfunction

   task automatic send_item(input abae_pkg::req_type it);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_stream(input int unsigned len, input stream_style_type style,
                              input bit closed);
      logic [7:0] base, alt, b;
      base = 8'($urandom_range(0, 255));
      alt  = 8'($urandom_range(0, 255));
      repeat (len) begin
         case (style)
            STYLE_RUN: begin
               b = base;
            end
            STYLE_PAIR: begin
               b = ($urandom_range(0, 3) == 0) ? alt : base;
            end
            STYLE_SKEWED: begin
               for (int k = 0; k < 8; k++) b[k] = base[k] ^ ($urandom_range(0, 7) == 0);
            end
            STYLE_TEXT: begin
               b = 8'($urandom_range(8'h20, 8'h7e));
            end
            default: begin
               b = 8'($urandom_range(0, 255));
            end
         endcase
         send_item(byte_item(b));
      end
      if (closed) send_item(flush_item());
   endtask

   // receiver side: random stalls, one long hold-off on request
   initial begin
      int unsigned gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (steady ? 20 : $urandom_range(1, 12)) @(posedge clock);
         gap = pick_gap();
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned target, stream_no, r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: flush from reset, field extremes, back-to-back flushes, constant runs
      send_item(flush_item());
      send_item(byte_item(8'h00));
      send_item(byte_item(8'hff));
      send_item(byte_item(8'h80));
      send_item(byte_item(8'h01));
      send_item(byte_item(8'h7f));
      send_item(byte_item(8'hfe));
      send_item(byte_item(8'haa));
      send_item(byte_item(8'h55));
      send_item(flush_item());
      send_item(flush_item());
      repeat (6) send_item(byte_item(8'h00));
      send_item(flush_item());
      repeat (4) send_item(byte_item(8'hff));
      send_item(flush_item());
      wait_drained();

      target    = items_sent + RANDOM_ITEMS;
      stream_no = 0;
      while (items_sent < target) begin
         stream_no++;
         steady = (stream_no % 9 == 5);
         if (stream_no == 4) begin
            hold_receiver = 1'b1;
            send_stream(6, STYLE_RANDOM, 1'b1);
         end else if (stream_no == 8) begin
            send_stream(90, STYLE_RUN, 1'b1);
         end else begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
               send_item(flush_item());
            end else begin
               send_stream(($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 10),
                           stream_style_type'($urandom_range(0, 4)), r != 1);
            end
         end
         if (stream_no == 3 || $urandom_range(0, 5) == 0) wait_drained();
      end
      steady = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d items, %0d of them end-of-stream flushes", items_seen,
               flushes_seen);
      $display("%0d output bytes compared, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         if (pending != 0) $display("%0d expected output bytes never arrived", pending);
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
